>>> rtl/pcc_pkg.sv
// shared types, constants and register indexes for the clamped pid controller
package pcc_pkg;

   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FRAC_BITS_DEFAULT  = 16;

   // fixed formats
   localparam int INTEG_WIDTH = 48;   // integral accumulator
   localparam int STEP_WIDTH  = 16;   // step time, unsigned q0.16
   localparam int STEP_FRAC   = 16;
   localparam int TERM_EXP    = 61;   // each term saturates at +-2^61
   localparam int TERM_WIDTH  = 63;
   localparam int DRIVE_SUM_WIDTH = 64;

   localparam logic [STEP_WIDTH-1:0] STEP_TIME_RESET = 16'd1638;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SETPOINT       = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_P         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_I         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_D_OVER_DT = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_TIME      = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LOW     = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_HIGH    = 3'd7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ERR,
      S_INC_START,
      S_INC_WAIT,
      S_INTEG_ADD,
      S_INTEG_CLAMP,
      S_TERM_START,
      S_TERM_WAIT,
      S_TERM_SAT,
      S_DRIVE_SUM,
      S_OUTPUT
   } state_type;

   // sequencer strobes to the datapath
   typedef struct packed {
      logic load_err;
      logic start_inc;
      logic load_raw;
      logic load_integ;
      logic start_term;
      logic load_terms;
      logic load_sum;
      logic load_rsp;
   } ctrl_type;

   // datapath status to the sequencer
   typedef struct packed {
      logic accept;
      logic inc_done;
      logic term_done;
      logic rsp_free;
   } stat_type;

endpackage

>>> rtl/pcc_serial_mult.sv
// bit-serial signed shift-add multiplier, one multiplier bit per cycle
module pcc_serial_mult #(
   parameter int MCAND_WIDTH  = 32,
   parameter int MPLIER_WIDTH = 48
)(
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic signed [MCAND_WIDTH-1:0]             mcand,
   input  logic signed [MPLIER_WIDTH-1:0]            mplier,
   output logic                                      done,
   output logic signed [MCAND_WIDTH+MPLIER_WIDTH:0]  product
);

   localparam int CNT_W = $clog2(MPLIER_WIDTH);

   logic signed [MCAND_WIDTH-1:0]  mcand_ff;
   logic signed [MCAND_WIDTH:0]    hi_ff, hi_in;
   logic [MPLIER_WIDTH-1:0]        lo_ff, lo_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           last;
   logic signed [MCAND_WIDTH+1:0]  addend, partial;

   assign last = (count_ff == CNT_W'(MPLIER_WIDTH - 1));

   always_comb begin
      // sign bit of the multiplier carries negative weight
      if (!lo_ff[0]) begin
         addend = '0;
      end else if (last) begin
         addend = -(MCAND_WIDTH+2)'(mcand_ff);
      end else begin
         addend = (MCAND_WIDTH+2)'(mcand_ff);
      end
      partial = (MCAND_WIDTH+2)'(hi_ff) + addend;
   end

   always_comb begin
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         hi_in    = '0;
         lo_in    = mplier;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in    = partial[MCAND_WIDTH+1:1];
         lo_in    = {partial[0], lo_ff[MPLIER_WIDTH-1:1]};
         count_in = count_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      if (start) begin
         mcand_ff <= mcand;
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

>>> rtl/pcc_ctrl.sv
// sequencer for one sample through error, integral, terms and output clamp
module pcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  pcc_pkg::stat_type  stat,
   output pcc_pkg::ctrl_type  ctrl,
   output logic               ready
);

   pcc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcc_pkg::S_IDLE: begin
            if (stat.accept) begin
               state_in = pcc_pkg::S_ERR;
            end
         end
         pcc_pkg::S_ERR:         state_in = pcc_pkg::S_INC_START;
         pcc_pkg::S_INC_START:   state_in = pcc_pkg::S_INC_WAIT;
         pcc_pkg::S_INC_WAIT: begin
            if (stat.inc_done) begin
               state_in = pcc_pkg::S_INTEG_ADD;
            end
         end
         pcc_pkg::S_INTEG_ADD:   state_in = pcc_pkg::S_INTEG_CLAMP;
         pcc_pkg::S_INTEG_CLAMP: state_in = pcc_pkg::S_TERM_START;
         pcc_pkg::S_TERM_START:  state_in = pcc_pkg::S_TERM_WAIT;
         pcc_pkg::S_TERM_WAIT: begin
            if (stat.term_done) begin
               state_in = pcc_pkg::S_TERM_SAT;
            end
         end
         pcc_pkg::S_TERM_SAT:    state_in = pcc_pkg::S_DRIVE_SUM;
         pcc_pkg::S_DRIVE_SUM:   state_in = pcc_pkg::S_OUTPUT;
         pcc_pkg::S_OUTPUT: begin
            if (stat.rsp_free) begin
               state_in = pcc_pkg::S_IDLE;
            end
         end
         default:                state_in = pcc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      ctrl  = '0;
      ready = 1'b0;
      case (state_ff)
         pcc_pkg::S_IDLE:        ready           = 1'b1;
         pcc_pkg::S_ERR:         ctrl.load_err   = 1'b1;
         pcc_pkg::S_INC_START:   ctrl.start_inc  = 1'b1;
         pcc_pkg::S_INTEG_ADD:   ctrl.load_raw   = 1'b1;
         pcc_pkg::S_INTEG_CLAMP: ctrl.load_integ = 1'b1;
         pcc_pkg::S_TERM_START:  ctrl.start_term = 1'b1;
         pcc_pkg::S_TERM_SAT:    ctrl.load_terms = 1'b1;
         pcc_pkg::S_DRIVE_SUM:   ctrl.load_sum   = 1'b1;
         pcc_pkg::S_OUTPUT:      ctrl.load_rsp   = stat.rsp_free;
         default:                ctrl           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcc_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/pid_controller_clamped_core.sv
// top level of the clamped pid controller with bit-serial multipliers
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  tdata: measured
//  rsp      out        rsp_tvalid/rsp_tready  tdata: drive; tuser: output_clamped,
//                                             integral_clamped
//  csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// each word passes through two serial multiply passes, first the error times
// the step time, then the three gain products side by side
// reset is synchronous and clears the sequencer, the integral, the previous
// error, the output valid and the configuration registers to their defaults
// the result sits in an output register, so the next word is taken while a
// result still waits; only the final load waits on rsp_tready
module pid_controller_clamped_core #(
   parameter int DATA_WIDTH = pcc_pkg::DATA_WIDTH_DEFAULT,
   parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEFAULT,
   localparam int TD_W      = ((DATA_WIDTH + 7) / 8) * 8
)(
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [TD_W-1:0]                      req_tdata,   // measured
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [TD_W-1:0]                      rsp_tdata,   // drive
   output logic [1:0]                           rsp_tuser,   // output_clamped, integral_clamped
   input  logic                                 csr_we,
   input  logic [pcc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [DATA_WIDTH-1:0]                csr_wdata
);

   localparam int W       = DATA_WIDTH;
   localparam int ERR_W   = W + 1;                      // error kept exact
   localparam int DELTA_W = W + 2;
   localparam int IW      = pcc_pkg::INTEG_WIDTH;
   localparam int RAW_W   = IW + 2;                     // integral plus increment
   localparam int INC_N   = pcc_pkg::STEP_WIDTH + 1;    // step time with a zero sign bit
   localparam int INC_P   = ERR_W + INC_N + 1;
   localparam int TERM_N  = (DELTA_W > IW) ? DELTA_W : IW;
   localparam int TERM_P  = W + TERM_N + 1;
   localparam int SH_W    = TERM_P - FRAC_BITS;
   localparam int TW      = pcc_pkg::TERM_WIDTH;
   localparam int CMP_W   = (SH_W > TW) ? SH_W : TW;
   localparam int DSW     = pcc_pkg::DRIVE_SUM_WIDTH;

   localparam logic signed [CMP_W-1:0] T_MAX = $signed(CMP_W'(1) << pcc_pkg::TERM_EXP);
   localparam logic signed [CMP_W-1:0] T_MIN = -T_MAX;
   localparam logic signed [IW-1:0]    I_MAX = $signed({1'b0, {(IW-1){1'b1}}});
   localparam logic signed [IW-1:0]    I_MIN = $signed({1'b1, {(IW-1){1'b0}}});

   // configuration registers
   logic signed [W-1:0]                   setpoint_ff, gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [W-1:0]                   integral_limit_ff, output_low_ff, output_high_ff;
   logic [pcc_pkg::STEP_WIDTH-1:0]        step_time_ff;

   // sample state and datapath registers
   logic signed [W-1:0]                   measured_ff;
   logic signed [ERR_W-1:0]               err_ff, prev_err_ff;
   logic signed [DELTA_W-1:0]             delta_ff;
   logic signed [RAW_W-1:0]               raw_sum_ff, raw_sum_in;
   logic signed [IW-1:0]                  integral_sum_ff, integ_sat, integ_in;
   logic signed [IW-1:0]                  limit_ext;
   logic                                  iclamp_ff, iclamp_in;
   logic signed [TW-1:0]                  term_ff [3];
   logic signed [TW-1:0]                  term_in [3];
   logic signed [DSW-1:0]                 drive_sum_ff, high_ext, low_ext;

   // output register
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]                          drive_ff, drive_in;
   logic                                  oclamp_ff, oclamp_in, rsp_iclamp_ff;

   // multipliers
   logic signed [INC_P-1:0]               inc_prod;
   logic signed [ERR_W-1:0]               inc;
   logic                                  inc_done;
   logic signed [W-1:0]                   term_gain   [3];
   logic signed [TERM_N-1:0]              term_mplier [3];
   logic signed [TERM_P-1:0]              term_prod   [3];
   logic [2:0]                            term_done_vec;

   pcc_pkg::ctrl_type                     ctrl;
   pcc_pkg::stat_type                     stat;
   logic                                  req_accept;

   assign req_accept = req_tvalid && req_tready;

   assign stat.accept    = req_accept;
   assign stat.inc_done  = inc_done;
   assign stat.term_done = &term_done_vec;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_tready;

   pcc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl),
      .ready (req_tready)
   );

   // configuration writes; software must write only while the block is idle, which the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff       <= '0;
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         step_time_ff      <= pcc_pkg::STEP_TIME_RESET;
         integral_limit_ff <= $signed({1'b0, {(W-1){1'b1}}});
         output_low_ff     <= $signed({1'b1, {(W-1){1'b0}}});
         output_high_ff    <= $signed({1'b0, {(W-1){1'b1}}});
      end else if (csr_we) begin
         case (csr_index)
            pcc_pkg::CSR_SETPOINT:       setpoint_ff       <= $signed(csr_wdata);
            pcc_pkg::CSR_GAIN_P:         gain_p_ff         <= $signed(csr_wdata);
            pcc_pkg::CSR_GAIN_I:         gain_i_ff         <= $signed(csr_wdata);
            pcc_pkg::CSR_GAIN_D_OVER_DT: gain_d_ff         <= $signed(csr_wdata);
            pcc_pkg::CSR_STEP_TIME:      step_time_ff      <= csr_wdata[pcc_pkg::STEP_WIDTH-1:0];
            pcc_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= $signed(csr_wdata);
            pcc_pkg::CSR_OUTPUT_LOW:     output_low_ff     <= $signed(csr_wdata);
            pcc_pkg::CSR_OUTPUT_HIGH:    output_high_ff    <= $signed(csr_wdata);
            default:                     setpoint_ff       <= setpoint_ff;
         endcase
      end
   end

   // error times step time, shifted q0.16 back out; never reaches the term limit
   pcc_serial_mult #(
      .MCAND_WIDTH  (ERR_W),
      .MPLIER_WIDTH (INC_N)
   ) u_inc_mult (
      .clock   (clock),
      .reset   (reset),
      .start   (ctrl.start_inc),
      .mcand   (err_ff),
      .mplier  ($signed({1'b0, step_time_ff})),
      .done    (inc_done),
      .product (inc_prod)
   );

   // floor shift is a plain bit select of the two's complement product
   assign inc = inc_prod[pcc_pkg::STEP_FRAC +: ERR_W];

   // three gain products run side by side
   assign term_gain[0]   = gain_p_ff;
   assign term_gain[1]   = gain_i_ff;
   assign term_gain[2]   = gain_d_ff;
   assign term_mplier[0] = TERM_N'(err_ff);
   assign term_mplier[1] = TERM_N'(integral_sum_ff);
   assign term_mplier[2] = TERM_N'(delta_ff);

   for (genvar g = 0; g < 3; g++) begin : g_term
      pcc_serial_mult #(
         .MCAND_WIDTH  (W),
         .MPLIER_WIDTH (TERM_N)
      ) u_term_mult (
         .clock   (clock),
         .reset   (reset),
         .start   (ctrl.start_term),
         .mcand   (term_gain[g]),
         .mplier  (term_mplier[g]),
         .done    (term_done_vec[g]),
         .product (term_prod[g])
      );
   end

   // integral: saturate at storage width, then clamp from above only
   assign raw_sum_in = RAW_W'(integral_sum_ff) + RAW_W'(inc);
   assign limit_ext  = IW'(integral_limit_ff);

   always_comb begin
      if (raw_sum_ff > RAW_W'(I_MAX)) begin
         integ_sat = I_MAX;
      end else if (raw_sum_ff < RAW_W'(I_MIN)) begin
         integ_sat = I_MIN;
      end else begin
         integ_sat = raw_sum_ff[IW-1:0];
      end
      if (integ_sat > limit_ext) begin
         integ_in  = limit_ext;
         iclamp_in = 1'b1;
      end else begin
         integ_in  = integ_sat;
         iclamp_in = 1'b0;
      end
   end

   // floor shift by the fraction bits and symmetric term saturation
   always_comb begin
      logic signed [CMP_W-1:0] shifted;
      for (int i = 0; i < 3; i++) begin
         shifted = CMP_W'($signed(term_prod[i][TERM_P-1:FRAC_BITS]));
         if (shifted > T_MAX) begin
            term_in[i] = TW'(T_MAX);
         end else if (shifted < T_MIN) begin
            term_in[i] = TW'(T_MIN);
         end else begin
            term_in[i] = TW'(shifted);
         end
      end
   end

   // output clamp; with crossed limits a sum above the upper bound gets the upper bound, any other the lower
   assign high_ext = DSW'(output_high_ff);
   assign low_ext  = DSW'(output_low_ff);

   always_comb begin
      if (drive_sum_ff > high_ext) begin
         drive_in  = output_high_ff;
         oclamp_in = 1'b1;
      end else if (drive_sum_ff < low_ext) begin
         drive_in  = output_low_ff;
         oclamp_in = 1'b1;
      end else begin
         drive_in  = drive_sum_ff[W-1:0];
         oclamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         measured_ff <= $signed(req_tdata[W-1:0]);
      end
      if (ctrl.load_err) begin
         err_ff <= ERR_W'(measured_ff) - ERR_W'(setpoint_ff);
      end
      if (ctrl.start_inc) begin
         delta_ff <= DELTA_W'(err_ff) - DELTA_W'(prev_err_ff);
      end
      if (ctrl.load_raw) begin
         raw_sum_ff <= raw_sum_in;
      end
      if (ctrl.load_integ) begin
         iclamp_ff <= iclamp_in;
      end
      if (ctrl.load_terms) begin
         for (int i = 0; i < 3; i++) begin
            term_ff[i] <= term_in[i];
         end
      end
      if (ctrl.load_sum) begin
         drive_sum_ff <= DSW'(term_ff[0]) + DSW'(term_ff[1]) + DSW'(term_ff[2]);
      end
      if (ctrl.load_rsp) begin
         drive_ff      <= drive_in;
         oclamp_ff     <= oclamp_in;
         rsp_iclamp_ff <= iclamp_ff;
      end
   end

   // controller state carried from sample to sample
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_sum_ff <= '0;
         prev_err_ff     <= '0;
      end else if (ctrl.load_integ) begin
         integral_sum_ff <= integ_in;
         prev_err_ff     <= err_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TD_W'(drive_ff);
   assign rsp_tuser  = {rsp_iclamp_ff, oclamp_ff};

   // a result is only loaded into a free output register
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over a waiting word");

   // the integral never ends above its limit
   a_integral_limit: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_integ |=> (integral_sum_ff <= limit_ext))
      else $error("integral above limit");

   // an unflagged drive lies within the output limits
   a_drive_bounds: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |=> (oclamp_ff ||
         (($signed(drive_ff) <= output_high_ff) && ($signed(drive_ff) >= output_low_ff))))
      else $error("unclamped drive outside limits");

   // the increment product is consumed right after it completes
   a_inc_handoff: assert property (@(posedge clock) disable iff (reset)
      inc_done |=> ctrl.load_raw)
      else $error("integral add missed the increment");

endmodule
